// ----- src/pso_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_pkg
// Shared widths, constants, codes and control types of the particle swarm
// update engine.
// ----------------------------------------------------------------------------
package pso_pkg;

   localparam int PARTICLES = 16;
   localparam int DIMS      = 8;
   localparam int PART_W    = 4;
   localparam int DIM_W     = 3;
   localparam int ADDR_W    = PART_W + DIM_W;
   localparam int SLOTS     = PARTICLES * DIMS;

   localparam int WORD_W    = 32;
   localparam int POS_W     = 19;
   localparam int GAIN_W    = 16;
   localparam int RAND_W    = 16;
   localparam int CSR_IDX_W = 2;

   // shared multiplier operands and product
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = 21;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = 38;
   localparam int SUM_W     = WORD_W + 1;
   localparam int T0_SHIFT  = 12;
   localparam int TX_SHIFT  = 44;
   localparam int TX_W      = PROD_W - TX_SHIFT;

   localparam logic signed [POS_W-1:0]  POS_LIMIT = 19'sd131072;
   localparam logic signed [POS_W-1:0]  POS_ONE   = 19'sd65536;
   localparam logic signed [WORD_W-1:0] WORD_MAX  = 32'sh7fff_ffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] COST_MAX  = WORD_MAX;

   localparam logic [GAIN_W-1:0] INERTIA_RESET = 16'd2048;
   localparam logic [GAIN_W-1:0] OWN_RESET     = 16'd6144;
   localparam logic [GAIN_W-1:0] SWARM_RESET   = 16'd10240;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_MOVE = 2'd1,
      ACT_COST = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INERTIA = 2'd0,
      CSR_OWN     = 2'd1,
      CSR_SWARM   = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WV,
      ST_KP,
      ST_TP,
      ST_KG,
      ST_TG,
      ST_SUM,
      ST_POS,
      ST_BNC,
      ST_CMP,
      ST_COPY,
      ST_CEND,
      ST_NUL
   } state_type;

   typedef enum logic [2:0] {
      MOP_WV,
      MOP_KP,
      MOP_TP,
      MOP_KG,
      MOP_TG
   } mop_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_T0,
      ACC_TX
   } acc_type;

   typedef enum logic [1:0] {
      RSP_NONE,
      RSP_MOVE,
      RSP_COST,
      RSP_ZERO
   } rsp_type;

   typedef struct packed {
      logic             take;
      logic             mul_en;
      mop_type          mop;
      acc_type          acc;
      logic             fin_sum;
      logic             fin_bnc;
      logic             cmp;
      logic             copy_rd;
      logic [DIM_W-1:0] copy_dim;
      rsp_type          rsp;
   } ctl_type;

endpackage

// ----- src/pso_mult.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_mult
// Shared signed multiplier with a registered product, reused for every
// product of a move.
// ----------------------------------------------------------------------------
module pso_mult (
   input  logic                                 clock,
   input  logic                                 mul_en,
   input  logic signed [pso_pkg::MUL_A_W-1:0]   mul_a,
   input  logic signed [pso_pkg::MUL_B_W-1:0]   mul_b,
   output logic signed [pso_pkg::PROD_W-1:0]    prod
);

   logic signed [pso_pkg::PROD_W-1:0] prod_ff;
   logic signed [pso_pkg::PROD_W-1:0] prod_in;

   assign prod_in = pso_pkg::PROD_W'(mul_a) * pso_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- src/pso_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_seq
// Sequencer: walks a move through the shared multiplier, a cost report
// through its compare and row copy, and raises the response strobe.
// ----------------------------------------------------------------------------
module pso_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  pso_pkg::action_type  action,
   input  logic                 any_hit,
   output logic                 busy,
   output pso_pkg::ctl_type     ctl
);

   pso_pkg::state_type            state_ff;
   pso_pkg::state_type            state_in;
   logic [pso_pkg::DIM_W-1:0]     cnt_ff;
   logic [pso_pkg::DIM_W-1:0]     cnt_in;
   logic                          take;
   logic                          cnt_last;

   assign take     = start && (state_ff == pso_pkg::ST_IDLE);
   assign cnt_last = (cnt_ff == pso_pkg::DIM_W'(pso_pkg::DIMS - 1));
   assign busy     = (state_ff != pso_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pso_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pso_pkg::ST_IDLE: begin
            if (take) begin
               case (action)
                  pso_pkg::ACT_LOAD: state_in = pso_pkg::ST_BNC;
                  pso_pkg::ACT_MOVE: state_in = pso_pkg::ST_WV;
                  pso_pkg::ACT_COST: state_in = pso_pkg::ST_CMP;
                  default:           state_in = pso_pkg::ST_NUL;
               endcase
            end
         end
         pso_pkg::ST_WV:   state_in = pso_pkg::ST_KP;
         pso_pkg::ST_KP:   state_in = pso_pkg::ST_TP;
         pso_pkg::ST_TP:   state_in = pso_pkg::ST_KG;
         pso_pkg::ST_KG:   state_in = pso_pkg::ST_TG;
         pso_pkg::ST_TG:   state_in = pso_pkg::ST_SUM;
         pso_pkg::ST_SUM:  state_in = pso_pkg::ST_POS;
         pso_pkg::ST_POS:  state_in = pso_pkg::ST_BNC;
         pso_pkg::ST_BNC:  state_in = pso_pkg::ST_IDLE;
         pso_pkg::ST_CMP:  state_in = any_hit ? pso_pkg::ST_COPY : pso_pkg::ST_CEND;
         pso_pkg::ST_COPY: state_in = cnt_last ? pso_pkg::ST_CEND : pso_pkg::ST_COPY;
         pso_pkg::ST_CEND: state_in = pso_pkg::ST_IDLE;
         pso_pkg::ST_NUL:  state_in = pso_pkg::ST_IDLE;
         default:          state_in = pso_pkg::ST_IDLE;
      endcase
   end

   assign cnt_in = (state_ff == pso_pkg::ST_COPY) ? cnt_ff + 1'b1 : '0;

   // outputs
   always_comb begin
      ctl          = '0;
      ctl.take     = take;
      ctl.mop      = pso_pkg::MOP_WV;
      ctl.acc      = pso_pkg::ACC_HOLD;
      ctl.rsp      = pso_pkg::RSP_NONE;
      ctl.copy_dim = cnt_ff;
      unique case (state_ff)
         pso_pkg::ST_IDLE: ;
         pso_pkg::ST_WV: begin
            ctl.mul_en = 1'b1;
            ctl.mop    = pso_pkg::MOP_WV;
         end
         pso_pkg::ST_KP: begin
            ctl.mul_en = 1'b1;
            ctl.mop    = pso_pkg::MOP_KP;
            ctl.acc    = pso_pkg::ACC_T0;
         end
         pso_pkg::ST_TP: begin
            ctl.mul_en = 1'b1;
            ctl.mop    = pso_pkg::MOP_TP;
         end
         pso_pkg::ST_KG: begin
            ctl.mul_en = 1'b1;
            ctl.mop    = pso_pkg::MOP_KG;
            ctl.acc    = pso_pkg::ACC_TX;
         end
         pso_pkg::ST_TG: begin
            ctl.mul_en = 1'b1;
            ctl.mop    = pso_pkg::MOP_TG;
         end
         pso_pkg::ST_SUM:  ctl.acc = pso_pkg::ACC_TX;
         pso_pkg::ST_POS:  ctl.fin_sum = 1'b1;
         pso_pkg::ST_BNC: begin
            ctl.fin_bnc = 1'b1;
            ctl.rsp     = pso_pkg::RSP_MOVE;
         end
         pso_pkg::ST_CMP:  ctl.cmp = 1'b1;
         pso_pkg::ST_COPY: ctl.copy_rd = 1'b1;
         pso_pkg::ST_CEND: ctl.rsp = pso_pkg::RSP_COST;
         pso_pkg::ST_NUL:  ctl.rsp = pso_pkg::RSP_ZERO;
         default: ;
      endcase
   end

endmodule

// ----- src/particle_swarm_update_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_swarm_update_top
// Particle swarm update engine in Q16.16: load, move and cost report items
// over per-particle position, velocity and own-best stores and a swarm best.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  req       start / busy           action, particle, dimension, load data,
//                                   random factors, cost
//  rsp       rsp_valid strobe       new position, new velocity, two flags
//  csr       csr_valid / csr_ready  csr_index, csr_data (16-bit gain)
//
//  steps from accept to strobe: load goes straight to the store write and reflect;
//  move makes five passes through the one shared multiplier, then sum and reflect;
//  cost report compares and, with a new best, copies the row (one position memory
//  read a cycle) before its strobe; an unused action gives a zeroed strobe.
//  busy is low in the strobe cycle, so the next beat can start there.
//  reset is synchronous; no clearing pass, stores without a reset value are
//  read only after a load. the receiver takes every strobe, nothing stalls.
// ----------------------------------------------------------------------------
module particle_swarm_update_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_action,
   input  logic [pso_pkg::PART_W-1:0]         req_particle,
   input  logic [pso_pkg::DIM_W-1:0]          req_dimension,
   input  logic signed [pso_pkg::WORD_W-1:0]  req_load_position,
   input  logic signed [pso_pkg::WORD_W-1:0]  req_load_velocity,
   input  logic [pso_pkg::RAND_W-1:0]         req_rand_own,
   input  logic [pso_pkg::RAND_W-1:0]         req_rand_swarm,
   input  logic signed [pso_pkg::WORD_W-1:0]  req_cost,
   output logic                               rsp_valid,
   output logic signed [pso_pkg::POS_W-1:0]   rsp_new_position,
   output logic signed [pso_pkg::WORD_W-1:0]  rsp_new_velocity,
   output logic                               rsp_own_improved,
   output logic                               rsp_swarm_improved,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pso_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pso_pkg::GAIN_W-1:0]         csr_data
);

   localparam int POS_W  = pso_pkg::POS_W;
   localparam int WORD_W = pso_pkg::WORD_W;
   localparam int ACC_W  = pso_pkg::ACC_W;
   localparam int SUM_W  = pso_pkg::SUM_W;
   localparam int A_W    = pso_pkg::MUL_A_W;
   localparam int B_W    = pso_pkg::MUL_B_W;
   localparam int P_W    = pso_pkg::PROD_W;

   localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(pso_pkg::POS_LIMIT);
   localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(pso_pkg::POS_LIMIT);

   pso_pkg::ctl_type ctl;
   logic             any_hit;

   // configuration
   logic [pso_pkg::GAIN_W-1:0] inertia_ff;
   logic [pso_pkg::GAIN_W-1:0] own_gain_ff;
   logic [pso_pkg::GAIN_W-1:0] swarm_gain_ff;

   // captured item
   pso_pkg::action_type              action_ff;
   logic [pso_pkg::PART_W-1:0]       particle_ff;
   logic [pso_pkg::DIM_W-1:0]        dim_ff;
   logic [pso_pkg::RAND_W-1:0]       rand_own_ff;
   logic [pso_pkg::RAND_W-1:0]       rand_swarm_ff;
   logic signed [WORD_W-1:0]         cost_ff;

   // working values
   logic signed [POS_W-1:0]   x_ff;
   logic signed [WORD_W-1:0]  v_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;

   // stores
   logic signed [POS_W-1:0]   pos_mem   [pso_pkg::SLOTS];
   logic signed [WORD_W-1:0]  vel_mem   [pso_pkg::SLOTS];
   logic signed [POS_W-1:0]   pbest_mem [pso_pkg::SLOTS];
   logic signed [POS_W-1:0]   pos_q;
   logic signed [WORD_W-1:0]  vel_q;
   logic signed [POS_W-1:0]   pbest_q;
   logic signed [WORD_W-1:0]  own_cost_ff [pso_pkg::PARTICLES];
   logic signed [WORD_W-1:0]  swarm_cost_ff;
   logic signed [POS_W-1:0]   swarm_pos_ff [pso_pkg::DIMS];
   logic                      own_hit_ff;
   logic                      swarm_hit_ff;
   logic                      own_hit;
   logic                      swarm_hit;
   logic                      copy_wr_ff;
   logic [pso_pkg::DIM_W-1:0] copy_dim_ff;

   logic [pso_pkg::ADDR_W-1:0] req_addr;
   logic [pso_pkg::ADDR_W-1:0] item_addr;
   logic [pso_pkg::ADDR_W-1:0] pos_rd_addr;
   logic                       pos_rd_en;

   // multiplier
   logic signed [A_W-1:0]     mul_a;
   logic signed [B_W-1:0]     mul_b;
   logic signed [P_W-1:0]     prod;
   logic signed [B_W-1:0]     diff_own;
   logic signed [B_W-1:0]     diff_swarm;
   logic signed [POS_W-1:0]   gbest;

   // finishing
   logic signed [WORD_W-1:0]  v_sat;
   logic signed [SUM_W-1:0]   x_sum;
   logic signed [POS_W-1:0]   x_clamp;
   logic signed [POS_W-1:0]   load_clamp;
   logic signed [POS_W-1:0]   x_out;
   logic signed [WORD_W-1:0]  v_out;
   logic                      flip;

   // response
   logic                      rsp_valid_ff;
   logic signed [POS_W-1:0]   rsp_pos_ff;
   logic signed [WORD_W-1:0]  rsp_vel_ff;
   logic                      rsp_own_ff;
   logic                      rsp_swarm_ff;

   function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [SUM_W-1:0] val);
      logic signed [POS_W-1:0] res;
      if (val > SUM_HI) begin
         res = pso_pkg::POS_LIMIT;
      end else if (val < SUM_LO) begin
         res = -pso_pkg::POS_LIMIT;
      end else begin
         res = val[POS_W-1:0];
      end
      return res;
   endfunction

   pso_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .action  (pso_pkg::action_type'(req_action)),
      .any_hit (any_hit),
      .busy    (busy),
      .ctl     (ctl)
   );

   pso_mult u_mult (
      .clock  (clock),
      .mul_en (ctl.mul_en),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod   (prod)
   );

   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inertia_ff    <= pso_pkg::INERTIA_RESET;
         own_gain_ff   <= pso_pkg::OWN_RESET;
         swarm_gain_ff <= pso_pkg::SWARM_RESET;
      end else if (csr_valid) begin
         unique case (pso_pkg::csr_index_type'(csr_index))
            pso_pkg::CSR_INERTIA: inertia_ff    <= csr_data;
            pso_pkg::CSR_OWN:     own_gain_ff   <= csr_data;
            pso_pkg::CSR_SWARM:   swarm_gain_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (ctl.take) begin
         action_ff     <= pso_pkg::action_type'(req_action);
         particle_ff   <= req_particle;
         dim_ff        <= req_dimension;
         rand_own_ff   <= req_rand_own;
         rand_swarm_ff <= req_rand_swarm;
         cost_ff       <= req_cost;
      end
   end

   assign req_addr    = {req_particle, req_dimension};
   assign item_addr   = {particle_ff, dim_ff};
   assign pos_rd_en   = ctl.take || ctl.copy_rd;
   assign pos_rd_addr = ctl.copy_rd ? {particle_ff, ctl.copy_dim} : req_addr;

   // position store: written on finish, read on accept and during the row copy
   always_ff @(posedge clock) begin
      if (ctl.fin_bnc) begin
         pos_mem[item_addr] <= x_out;
      end
      if (pos_rd_en) begin
         pos_q <= pos_mem[pos_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fin_bnc) begin
         vel_mem[item_addr] <= v_out;
      end
      if (ctl.take) begin
         vel_q <= vel_mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fin_bnc && (action_ff == pso_pkg::ACT_LOAD)) begin
         pbest_mem[item_addr] <= x_out;
      end else if (copy_wr_ff && own_hit_ff) begin
         pbest_mem[{particle_ff, copy_dim_ff}] <= pos_q;
      end
      if (ctl.take) begin
         pbest_q <= pbest_mem[req_addr];
      end
   end

   // operand select for the shared multiplier
   assign gbest      = swarm_pos_ff[dim_ff];
   assign diff_own   = B_W'(pbest_q) - B_W'(pos_q);
   assign diff_swarm = B_W'(gbest) - B_W'(pos_q);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctl.mop)
         pso_pkg::MOP_WV: begin
            mul_a = A_W'(vel_q);
            mul_b = {{(B_W - pso_pkg::GAIN_W){1'b0}}, inertia_ff};
         end
         pso_pkg::MOP_KP: begin
            mul_a = {{(A_W - pso_pkg::GAIN_W){1'b0}}, own_gain_ff};
            mul_b = {{(B_W - pso_pkg::RAND_W){1'b0}}, rand_own_ff};
         end
         pso_pkg::MOP_TP: begin
            mul_a = {1'b0, prod[WORD_W-1:0]};
            mul_b = diff_own;
         end
         pso_pkg::MOP_KG: begin
            mul_a = {{(A_W - pso_pkg::GAIN_W){1'b0}}, swarm_gain_ff};
            mul_b = {{(B_W - pso_pkg::RAND_W){1'b0}}, rand_swarm_ff};
         end
         pso_pkg::MOP_TG: begin
            mul_a = {1'b0, prod[WORD_W-1:0]};
            mul_b = diff_swarm;
         end
         default: ;
      endcase
   end

   // floored terms summed in the accumulator
   always_comb begin
      acc_in = acc_ff;
      case (ctl.acc)
         pso_pkg::ACC_T0: acc_in = prod[ACC_W+pso_pkg::T0_SHIFT-1:pso_pkg::T0_SHIFT];
         pso_pkg::ACC_TX: acc_in = acc_ff + ACC_W'($signed(prod[P_W-1:pso_pkg::TX_SHIFT]));
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // saturate velocity, add to position, clamp
   always_comb begin
      if ((acc_ff[ACC_W-1:WORD_W-1] == '0) || (acc_ff[ACC_W-1:WORD_W-1] == '1)) begin
         v_sat = acc_ff[WORD_W-1:0];
      end else begin
         v_sat = acc_ff[ACC_W-1] ? pso_pkg::WORD_MIN : pso_pkg::WORD_MAX;
      end
   end

   assign x_sum      = SUM_W'(pos_q) + SUM_W'(v_sat);
   assign x_clamp    = clamp_pos(x_sum);
   assign load_clamp = clamp_pos(SUM_W'(req_load_position));

   always_ff @(posedge clock) begin
      if (ctl.take) begin
         x_ff <= load_clamp;
         v_ff <= req_load_velocity;
      end else if (ctl.fin_sum) begin
         x_ff <= x_clamp;
         v_ff <= v_sat;
      end
   end

   // reflect about +-1
   always_comb begin
      flip  = 1'b0;
      x_out = x_ff;
      if (x_ff > pso_pkg::POS_ONE) begin
         x_out = pso_pkg::POS_LIMIT - x_ff;
         flip  = 1'b1;
      end else if (x_ff < -pso_pkg::POS_ONE) begin
         x_out = -pso_pkg::POS_LIMIT - x_ff;
         flip  = 1'b1;
      end
      if (!flip) begin
         v_out = v_ff;
      end else if (v_ff == pso_pkg::WORD_MIN) begin
         v_out = pso_pkg::WORD_MAX;
      end else begin
         v_out = -v_ff;
      end
   end

   // best cost tracking
   assign own_hit   = cost_ff < own_cost_ff[particle_ff];
   assign swarm_hit = cost_ff < swarm_cost_ff;
   assign any_hit   = own_hit || swarm_hit;

   always_ff @(posedge clock) begin
      if (ctl.cmp) begin
         own_hit_ff   <= own_hit;
         swarm_hit_ff <= swarm_hit;
      end
      copy_dim_ff <= ctl.copy_dim;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pso_pkg::PARTICLES; i++) begin
            own_cost_ff[i] <= pso_pkg::COST_MAX;
         end
         swarm_cost_ff <= pso_pkg::COST_MAX;
         copy_wr_ff    <= 1'b0;
      end else begin
         copy_wr_ff <= ctl.copy_rd;
         if (ctl.fin_bnc && (action_ff == pso_pkg::ACT_LOAD)) begin
            own_cost_ff[particle_ff] <= pso_pkg::COST_MAX;
         end else if (ctl.cmp && own_hit) begin
            own_cost_ff[particle_ff] <= cost_ff;
         end
         if (ctl.cmp && swarm_hit) begin
            swarm_cost_ff <= cost_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pso_pkg::DIMS; i++) begin
            swarm_pos_ff[i] <= '0;
         end
      end else if (copy_wr_ff && swarm_hit_ff) begin
         swarm_pos_ff[copy_dim_ff] <= pos_q;
      end
   end

   // response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (ctl.rsp != pso_pkg::RSP_NONE);
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.rsp)
         pso_pkg::RSP_MOVE: begin
            rsp_pos_ff   <= x_out;
            rsp_vel_ff   <= v_out;
            rsp_own_ff   <= 1'b0;
            rsp_swarm_ff <= 1'b0;
         end
         pso_pkg::RSP_COST: begin
            rsp_pos_ff   <= '0;
            rsp_vel_ff   <= '0;
            rsp_own_ff   <= own_hit_ff;
            rsp_swarm_ff <= swarm_hit_ff;
         end
         pso_pkg::RSP_ZERO: begin
            rsp_pos_ff   <= '0;
            rsp_vel_ff   <= '0;
            rsp_own_ff   <= 1'b0;
            rsp_swarm_ff <= 1'b0;
         end
         default: ;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_new_position   = rsp_pos_ff;
   assign rsp_new_velocity   = rsp_vel_ff;
   assign rsp_own_improved   = rsp_own_ff;
   assign rsp_swarm_improved = rsp_swarm_ff;

endmodule

// ----- src/pso_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_chk
// Port-level checks of the particle swarm update engine, bound to the top.
// ----------------------------------------------------------------------------
module pso_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic signed [pso_pkg::POS_W-1:0]   rsp_new_position,
   input logic signed [pso_pkg::WORD_W-1:0]  rsp_new_velocity,
   input logic                               rsp_own_improved,
   input logic                               rsp_swarm_improved
);

   localparam logic signed [pso_pkg::POS_W-1:0] ONE = pso_pkg::POS_ONE;

   // an accepted beat always makes the engine busy
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("engine not busy after accepting a beat");

   // the strobe comes as the engine returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // no two responses in consecutive cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // a cost report result carries no position or velocity
   a_cost_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_own_improved || rsp_swarm_improved))
         |-> (rsp_new_position == '0 && rsp_new_velocity == '0))
      else $error("improvement flag with nonzero position or velocity");

   // reflected positions stay within plus or minus one
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_new_position <= ONE && rsp_new_position >= -ONE))
      else $error("position outside the reflected range");

endmodule

bind particle_swarm_update_top pso_chk u_pso_chk (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_new_position   (rsp_new_position),
   .rsp_new_velocity   (rsp_new_velocity),
   .rsp_own_improved   (rsp_own_improved),
   .rsp_swarm_improved (rsp_swarm_improved)
);

// ----- test/tb_particle_swarm_update_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_swarm_update_top
// Self-checking bench for the particle swarm update engine. Commands go in
// through start/busy from a queue, and an in-bench model of the Q16.16
// load, move and cost-report arithmetic predicts each update beat. Every
// strobe is checked field by field against the oldest prediction. Gains are
// changed between phases while the engine is idle.
// ----------------------------------------------------------------------------
module tb_particle_swarm_update_top;

   localparam int          WORD_W      = pso_pkg::WORD_W;
   localparam int          POS_W       = pso_pkg::POS_W;
   localparam int          PART_W      = pso_pkg::PART_W;
   localparam int          DIM_W       = pso_pkg::DIM_W;
   localparam int          RAND_W      = pso_pkg::RAND_W;
   localparam int          GAIN_W      = pso_pkg::GAIN_W;
   localparam int          CSR_IDX_W   = pso_pkg::CSR_IDX_W;
   localparam int          SLOTS       = pso_pkg::SLOTS;
   localparam int          PARTICLES   = pso_pkg::PARTICLES;
   localparam int          DIMS        = pso_pkg::DIMS;

   localparam int          CLK_HALF    = 6;
   localparam int          CYCLE_LIMIT = 600000;
   localparam int          PHASE_CMDS  = 320;
   localparam int          QUIET_FROM  = 700;
   localparam int          QUIET_TO    = 1000;
   localparam logic [1:0]  ACT_NONE    = 2'd3;
   localparam logic [1:0]  CSR_UNUSED  = 2'd3;
   localparam logic signed [WORD_W-1:0] COST_HI = 32'sd1500000000;

   typedef struct packed {
      logic [1:0]        action;
      logic [PART_W-1:0] particle;
      logic [DIM_W-1:0]  dimension;
      logic [WORD_W-1:0] load_position;
      logic [WORD_W-1:0] load_velocity;
      logic [RAND_W-1:0] rand_own;
      logic [RAND_W-1:0] rand_swarm;
      logic [WORD_W-1:0] cost;
   } swarm_cmd_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] vel;
      logic              own;
      logic              swarm;
   } swarm_update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]                 req_action        = '0;
   logic [PART_W-1:0]          req_particle      = '0;
   logic [DIM_W-1:0]           req_dimension     = '0;
   logic signed [WORD_W-1:0]   req_load_position = '0;
   logic signed [WORD_W-1:0]   req_load_velocity = '0;
   logic [RAND_W-1:0]          req_rand_own      = '0;
   logic [RAND_W-1:0]          req_rand_swarm    = '0;
   logic signed [WORD_W-1:0]   req_cost          = '0;
   logic                       rsp_valid;
   logic signed [POS_W-1:0]    rsp_new_position;
   logic signed [WORD_W-1:0]   rsp_new_velocity;
   logic                       rsp_own_improved;
   logic                       rsp_swarm_improved;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [GAIN_W-1:0]          csr_data  = '0;

   particle_swarm_update_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_particle       (req_particle),
      .req_dimension      (req_dimension),
      .req_load_position  (req_load_position),
      .req_load_velocity  (req_load_velocity),
      .req_rand_own       (req_rand_own),
      .req_rand_swarm     (req_rand_swarm),
      .req_cost           (req_cost),
      .rsp_valid          (rsp_valid),
      .rsp_new_position   (rsp_new_position),
      .rsp_new_velocity   (rsp_new_velocity),
      .rsp_own_improved   (rsp_own_improved),
      .rsp_swarm_improved (rsp_swarm_improved),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // swarm model state
   logic [GAIN_W-1:0]        inertia_w;
   logic [GAIN_W-1:0]        own_pull;
   logic [GAIN_W-1:0]        swarm_pull;
   logic signed [WORD_W-1:0] pos_mem      [SLOTS];
   logic signed [WORD_W-1:0] vel_mem      [SLOTS];
   logic signed [WORD_W-1:0] best_pos_mem [SLOTS];
   logic signed [WORD_W-1:0] best_cost    [PARTICLES];
   logic signed [WORD_W-1:0] swarm_pos    [DIMS];
   logic signed [WORD_W-1:0] swarm_cost;

   swarm_cmd_type    cmd_queue[$];
   swarm_update_type update_queue[$];

   // stimulus bookkeeping, touched only by the stimulus process
   bit     slot_loaded [SLOTS];
   longint cost_level = 64'sd1400000000;
   int     useful_count = 0;

   int  queued_count  = 0;
   int  checked_count = 0;
   int  sent_count    = 0;
   int  errors        = 0;
   int  cycles        = 0;
   logic req_taken    = 1'b0;

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d updates still outstanding", $time,
                  update_queue.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic signed [WORD_W-1:0] sat_word(input longint a);
      if (a > longint'(pso_pkg::WORD_MAX)) return pso_pkg::WORD_MAX;
      if (a < longint'(pso_pkg::WORD_MIN)) return pso_pkg::WORD_MIN;
      return a[WORD_W-1:0];
   endfunction

   // clamp to +-2, then fold back about +-1 and flip the velocity
   task automatic reflect(inout logic signed [WORD_W-1:0] x,
                          inout logic signed [WORD_W-1:0] v);
      logic signed [WORD_W-1:0] p;
      logic flip;
      p    = x;
      flip = 1'b0;
      if (p > pso_pkg::POS_LIMIT) p = pso_pkg::POS_LIMIT;
      if (p < -pso_pkg::POS_LIMIT) p = -pso_pkg::POS_LIMIT;
      if (p > pso_pkg::POS_ONE) begin
         p    = pso_pkg::POS_LIMIT - p;
         flip = 1'b1;
      end else if (p < -pso_pkg::POS_ONE) begin
         p    = -pso_pkg::POS_LIMIT - p;
         flip = 1'b1;
      end
      if (flip) v = sat_word(-longint'(v));
      x = p;
   endtask

   task automatic swarm_step(input swarm_cmd_type c, output swarm_update_type u);
      int slot;
      int row;
      longint x0, k1, k2, t0, t1, t2;
      logic signed [WORD_W-1:0] x, v, cst;
      u    = '0;
      row  = int'(c.particle) * DIMS;
      slot = row + int'(c.dimension);
      case (c.action)
         pso_pkg::ACT_LOAD: begin
            x = $signed(c.load_position);
            v = $signed(c.load_velocity);
            reflect(x, v);
            best_pos_mem[slot]   = x;
            best_cost[c.particle] = pso_pkg::COST_MAX;
            pos_mem[slot] = x;
            vel_mem[slot] = v;
            u.pos = x[POS_W-1:0];
            u.vel = v;
         end
         pso_pkg::ACT_MOVE: begin
            x0 = longint'(pos_mem[slot]);
            k1 = longint'(own_pull) * longint'(c.rand_own);
            k2 = longint'(swarm_pull) * longint'(c.rand_swarm);
            t0 = (longint'(inertia_w) * longint'(vel_mem[slot])) >>> pso_pkg::T0_SHIFT;
            t1 = (k1 * (longint'(best_pos_mem[slot]) - x0)) >>> pso_pkg::TX_SHIFT;
            t2 = (k2 * (longint'(swarm_pos[c.dimension]) - x0)) >>> pso_pkg::TX_SHIFT;
            v = sat_word(t0 + t1 + t2);
            x = sat_word(x0 + longint'(v));
            reflect(x, v);
            pos_mem[slot] = x;
            vel_mem[slot] = v;
            u.pos = x[POS_W-1:0];
            u.vel = v;
         end
         pso_pkg::ACT_COST: begin
            cst = $signed(c.cost);
            if (cst < best_cost[c.particle]) begin
               for (int i = 0; i < DIMS; i++) best_pos_mem[row + i] = pos_mem[row + i];
               best_cost[c.particle] = cst;
               u.own = 1'b1;
            end
            if (cst < swarm_cost) begin
               for (int i = 0; i < DIMS; i++) swarm_pos[i] = pos_mem[row + i];
               swarm_cost = cst;
               u.swarm = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   // sample side: check the strobe, track csr writes, predict accepted beats
   always @(posedge clock) begin : monitor
      swarm_cmd_type    c;
      swarm_update_type u;
      swarm_update_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            checked_count <= checked_count + 1;
            if (update_queue.size() == 0) begin
               $display("%0t: update beat with nothing outstanding", $time);
               errors = errors + 1;
            end else begin
               want = update_queue.pop_front();
               if (rsp_new_position !== want.pos) begin
                  $display("%0t: new_position expected %h actual %h", $time,
                           want.pos, rsp_new_position);
                  errors = errors + 1;
               end
               if (rsp_new_velocity !== want.vel) begin
                  $display("%0t: new_velocity expected %h actual %h", $time,
                           want.vel, rsp_new_velocity);
                  errors = errors + 1;
               end
               if (rsp_own_improved !== want.own) begin
                  $display("%0t: own_improved expected %b actual %b", $time,
                           want.own, rsp_own_improved);
                  errors = errors + 1;
               end
               if (rsp_swarm_improved !== want.swarm) begin
                  $display("%0t: swarm_improved expected %b actual %b", $time,
                           want.swarm, rsp_swarm_improved);
                  errors = errors + 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pso_pkg::CSR_INERTIA: inertia_w  = csr_data;
               pso_pkg::CSR_OWN:     own_pull   = csr_data;
               pso_pkg::CSR_SWARM:   swarm_pull = csr_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            c.action        = req_action;
            c.particle      = req_particle;
            c.dimension     = req_dimension;
            c.load_position = req_load_position;
            c.load_velocity = req_load_velocity;
            c.rand_own      = req_rand_own;
            c.rand_swarm    = req_rand_swarm;
            c.cost          = req_cost;
            swarm_step(c, u);
            update_queue.insert(update_queue.size(), u);
         end
         req_taken <= start && !busy;
      end
   end

   function automatic swarm_cmd_type rand_cmd();
      swarm_cmd_type c;
      c.action        = 2'($urandom_range(0, 3));
      c.particle      = PART_W'($urandom);
      c.dimension     = DIM_W'($urandom);
      c.load_position = $urandom;
      c.load_velocity = $urandom;
      c.rand_own      = RAND_W'($urandom);
      c.rand_swarm    = RAND_W'($urandom);
      c.cost          = $urandom;
      return c;
   endfunction

   // drive side: next beat from the queue, random gaps outside the quiet stretch
   always @(negedge clock) begin : driver
      swarm_cmd_type c;
      logic quiet;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         quiet = (sent_count >= QUIET_FROM) && (sent_count < QUIET_TO);
         if (cmd_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 27)) begin
            c = cmd_queue.pop_front();
            sent_count <= sent_count + 1;
            start <= 1'b1;
         end else begin
            c = rand_cmd();
            start <= 1'b0;
         end
         req_action        <= c.action;
         req_particle      <= c.particle;
         req_dimension     <= c.dimension;
         req_load_position <= c.load_position;
         req_load_velocity <= c.load_velocity;
         req_rand_own      <= c.rand_own;
         req_rand_swarm    <= c.rand_swarm;
         req_cost          <= c.cost;
      end
   end

   task automatic push_cmd(input swarm_cmd_type c);
      cmd_queue.insert(cmd_queue.size(), c);
      queued_count = queued_count + 1;
      if (c.action == pso_pkg::ACT_LOAD)
         slot_loaded[int'(c.particle) * DIMS + int'(c.dimension)] = 1'b1;
      if (c.action != ACT_NONE) useful_count = useful_count + 1;
   endtask

   task automatic queue_cmd(input logic [1:0] act, input int p, input int d,
                            input logic signed [WORD_W-1:0] lp,
                            input logic signed [WORD_W-1:0] lv,
                            input logic [RAND_W-1:0] ro, input logic [RAND_W-1:0] rs,
                            input logic signed [WORD_W-1:0] cst);
      swarm_cmd_type c;
      c.action        = act;
      c.particle      = PART_W'(p);
      c.dimension     = DIM_W'(d);
      c.load_position = lp;
      c.load_velocity = lv;
      c.rand_own      = ro;
      c.rand_swarm    = rs;
      c.cost          = cst;
      push_cmd(c);
   endtask

   function automatic bit row_loaded(input int p);
      for (int i = 0; i < DIMS; i++) if (!slot_loaded[p * DIMS + i]) return 1'b0;
      return 1'b1;
   endfunction

   // mostly near the reflection band, some extremes and full-range words
   function automatic logic signed [WORD_W-1:0] pick_word(input int span);
      case ($urandom_range(0, 9))
         0:       return pso_pkg::WORD_MAX;
         1:       return pso_pkg::WORD_MIN;
         2, 3:    return $urandom;
         default: return int'($urandom_range(0, 2 * span)) - span;
      endcase
   endfunction

   function automatic logic [RAND_W-1:0] pick_factor();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return RAND_W'($urandom);
      endcase
   endfunction

   // slowly falling cost level keeps swarm-best hits coming all run long
   function automatic logic signed [WORD_W-1:0] next_cost();
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return $urandom;
      if (r < 10) return sat_word(cost_level + longint'($urandom_range(0, 1 << 20)));
      cost_level = cost_level - longint'($urandom_range(0, 1 << 23));
      if (cost_level < longint'(pso_pkg::WORD_MIN) + 1)
         cost_level = longint'(pso_pkg::WORD_MIN) + 1;
      return sat_word(cost_level);
   endfunction

   task automatic gen_single();
      swarm_cmd_type c;
      int r;
      c = rand_cmd();
      r = $urandom_range(0, 99);
      if (r < 4) begin
         c.action = ACT_NONE;
      end else if (r < 28 || (r < 72 && !slot_loaded[int'(c.particle) * DIMS +
                                                     int'(c.dimension)])) begin
         c.action        = pso_pkg::ACT_LOAD;
         c.load_position = pick_word(150000);
         c.load_velocity = pick_word(20000);
      end else if (r < 72) begin
         c.action     = pso_pkg::ACT_MOVE;
         c.rand_own   = pick_factor();
         c.rand_swarm = pick_factor();
      end else begin
         c.action = pso_pkg::ACT_COST;
         // a row with unloaded slots may only report a cost that cannot win
         c.cost   = row_loaded(c.particle) ? next_cost() : pso_pkg::COST_MAX;
      end
      push_cmd(c);
   endtask

   // one particle at a time: fill the row, or move every dimension and report
   task automatic gen_sweep();
      int p;
      p = $urandom_range(0, PARTICLES - 1);
      if (row_loaded(p)) begin
         for (int d = 0; d < DIMS; d++)
            queue_cmd(pso_pkg::ACT_MOVE, p, d, $urandom, $urandom, pick_factor(),
                      pick_factor(), $urandom);
         queue_cmd(pso_pkg::ACT_COST, p, $urandom_range(0, DIMS - 1), $urandom, $urandom,
                   RAND_W'($urandom), RAND_W'($urandom), next_cost());
      end else begin
         for (int d = 0; d < DIMS; d++)
            queue_cmd(pso_pkg::ACT_LOAD, p, d, pick_word(150000), pick_word(20000),
                      RAND_W'($urandom), RAND_W'($urandom), $urandom);
      end
   endtask

   task automatic gen_random(input int n);
      int first;
      first = useful_count;
      while (useful_count - first < n) begin
         if ($urandom_range(0, 99) < 25) gen_sweep();
         else gen_single();
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_index <= CSR_IDX_W'($urandom);
      csr_data  <= GAIN_W'($urandom);
   endtask

   task automatic set_gains(input logic [GAIN_W-1:0] w, input logic [GAIN_W-1:0] p,
                            input logic [GAIN_W-1:0] g);
      int rot;
      rot = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
         case ((k + rot) % 3)
            0:       write_csr(pso_pkg::CSR_INERTIA, w);
            1:       write_csr(pso_pkg::CSR_OWN, p);
            default: write_csr(pso_pkg::CSR_SWARM, g);
         endcase
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (checked_count < queued_count) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      inertia_w  = pso_pkg::INERTIA_RESET;
      own_pull   = pso_pkg::OWN_RESET;
      swarm_pull = pso_pkg::SWARM_RESET;
      for (int i = 0; i < PARTICLES; i++) best_cost[i] = pso_pkg::COST_MAX;
      for (int i = 0; i < DIMS; i++) swarm_pos[i] = '0;
      swarm_cost = pso_pkg::COST_MAX;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed part at reset gains
      @(posedge clock);
      queue_cmd(pso_pkg::ACT_COST, 0, 0, 0, 0, 0, 0, pso_pkg::COST_MAX); // empty row
      queue_cmd(ACT_NONE, 9, 5, $urandom, $urandom, RAND_W'($urandom), RAND_W'($urandom),
                $urandom);
      queue_cmd(pso_pkg::ACT_LOAD, 0, 0, pso_pkg::WORD_MAX, pso_pkg::WORD_MIN, 0, 0, 0);
      queue_cmd(pso_pkg::ACT_LOAD, 0, 1, pso_pkg::WORD_MIN, pso_pkg::WORD_MAX, 0, 0, 0);
      queue_cmd(pso_pkg::ACT_LOAD, 0, 2, 32'sd98304, -32'sd5000, 0, 0, 0);
      queue_cmd(pso_pkg::ACT_LOAD, 0, 3, -32'sd65537, 32'sd12345, 0, 0, 0);
      queue_cmd(pso_pkg::ACT_LOAD, 0, 4, 32'sd65536, -32'sd1, 0, 0, 0);
      queue_cmd(pso_pkg::ACT_LOAD, 0, 5, -32'sd65536, 32'sd0, 0, 0, 0);
      queue_cmd(pso_pkg::ACT_LOAD, 0, 6, 32'sd65537, 32'sd100000, 0, 0, 0);
      queue_cmd(pso_pkg::ACT_LOAD, 0, 7, 32'sd0, 32'sd196608, 0, 0, 0);
      queue_cmd(pso_pkg::ACT_MOVE, 0, 0, 0, 0, '0, '0, 0);
      queue_cmd(pso_pkg::ACT_MOVE, 0, 7, 0, 0, '1, '1, 0);
      queue_cmd(pso_pkg::ACT_COST, 0, 0, 0, 0, 0, 0, COST_HI);
      queue_cmd(pso_pkg::ACT_COST, 0, 0, 0, 0, 0, 0, COST_HI);     // equal cost is no win
      queue_cmd(pso_pkg::ACT_COST, 0, 0, 0, 0, 0, 0, COST_HI - 1);
      queue_cmd(pso_pkg::ACT_LOAD, 0, 3, 32'sd20000, -32'sd300, 0, 0, 0);
      queue_cmd(pso_pkg::ACT_COST, 0, 0, 0, 0, 0, 0, COST_HI + 100); // own best only
      queue_cmd(pso_pkg::ACT_MOVE, 0, 3, 0, 0, '1, '0, 0);
      queue_cmd(pso_pkg::ACT_MOVE, 0, 5, 0, 0, '0, '1, 0);
      queue_cmd(pso_pkg::ACT_LOAD, PARTICLES - 1, DIMS - 1, pso_pkg::WORD_MAX,
                pso_pkg::WORD_MAX, 0, 0, 0);
      queue_cmd(pso_pkg::ACT_MOVE, PARTICLES - 1, DIMS - 1, 0, 0, RAND_W'($urandom),
                RAND_W'($urandom), 0);
      gen_random(PHASE_CMDS);
      wait_drained();

      for (int ph = 1; ph <= 5; ph++) begin
         case (ph)
            1: set_gains('1, '1, '1);
            2: set_gains('0, '0, '0);
            3: begin
               set_gains(16'd4096, 16'd4096, 16'd4096);
               write_csr(CSR_UNUSED, GAIN_W'($urandom));
            end
            4: set_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
            default: set_gains(GAIN_W'($urandom_range(0, 8191)), '1, '0);
         endcase
         @(posedge clock);
         gen_random(PHASE_CMDS);
         if (ph == 5) begin
            // lowest cost wins once, then never again
            queue_cmd(pso_pkg::ACT_COST, 0, 0, 0, 0, 0, 0, pso_pkg::WORD_MIN);
            queue_cmd(pso_pkg::ACT_COST, 0, 0, 0, 0, 0, 0, pso_pkg::WORD_MIN);
            queue_cmd(pso_pkg::ACT_COST, 0, 0, 0, 0, 0, 0, pso_pkg::WORD_MAX);
         end
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (update_queue.size() != 0)
         $display("%0t: %0d updates never arrived", $time, update_queue.size());
      if (errors == 0 && update_queue.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
